/* hdl/srt_pkg.sv */
`default_nettype none

package srt_pkg;

    // Fixed field widths of the request and result beats.
    localparam int DATA_W       = 32;
    localparam int OP_W         = 2;
    localparam int POS_W        = 7;
    localparam int CNT_OUT_W    = 7;
    localparam int STATUS_W     = 2;
    localparam int CAPACITY_DEF = 64;

    // Request operation codes.
    typedef enum logic [OP_W-1:0] {
        OP_INSERT = 2'd0,
        OP_GET    = 2'd1,
        OP_REMOVE = 2'd2
    } t_op;

    // Result status codes.
    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_RANGE = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    // Command broadcast from the controller to every cell.
    typedef enum logic [2:0] {
        CELL_HOLD,
        CELL_INSERT,
        CELL_REMOVE,
        CELL_LOAD,
        CELL_SHIFT
    } t_cell_op;

    typedef struct packed {
        t_cell_op                 op;
        logic signed [DATA_W-1:0] value;
    } t_cell_cmd;

    // Controller states.
    typedef enum logic {
        S_IDLE,
        S_SCAN
    } t_state;

endpackage

`default_nettype wire

/* hdl/srt_cell.sv */
`default_nettype none

module srt_cell import srt_pkg::*; #(
    parameter int CMP_W = 7,
    parameter int INDEX = 0
) (
    input  wire logic                     i_clk,
    input  wire t_cell_cmd                i_cmd,
    input  wire logic [CMP_W-1:0]         i_count,
    input  wire logic [CMP_W-1:0]         i_rank_idx,
    input  wire logic                     i_left_gt,
    input  wire logic signed [DATA_W-1:0] i_left_entry,
    input  wire logic signed [DATA_W-1:0] i_right_entry,
    input  wire logic signed [DATA_W-1:0] i_right_pass,
    output logic                          o_gt,
    output logic signed [DATA_W-1:0]      o_entry,
    output logic signed [DATA_W-1:0]      o_pass
);

    logic signed [DATA_W-1:0] r_entry;
    logic signed [DATA_W-1:0] r_pass;
    logic                     w_occupied;
    logic                     w_at_or_after;

    // An empty slot acts as larger than any value, so the new value lands at
    // the end of the list when nothing stored exceeds it.
    assign w_occupied    = CMP_W'(INDEX) < i_count;
    assign w_at_or_after = CMP_W'(INDEX) >= i_rank_idx;
    assign o_gt          = !w_occupied || ($signed(r_entry) > $signed(i_cmd.value));

    // Stored entry: shift right on insert, shift left on remove.
    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            CELL_INSERT: begin
                if (o_gt) begin
                    r_entry <= i_left_gt ? i_left_entry : i_cmd.value;
                end
            end
            CELL_REMOVE: begin
                if (w_at_or_after) begin
                    r_entry <= i_right_entry;
                end
            end
            default: begin
                r_entry <= r_entry;
            end
        endcase
    end

    // Read-out chain: copy the entry, then move toward cell zero one step a cycle.
    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            CELL_LOAD:  r_pass <= r_entry;
            CELL_SHIFT: r_pass <= i_right_pass;
            default:    r_pass <= r_pass;
        endcase
    end

    assign o_entry = r_entry;
    assign o_pass  = r_pass;

endmodule

`default_nettype wire

/* hdl/srt_ctrl.sv */
`default_nettype none

module srt_ctrl import srt_pkg::*; #(
    parameter int CAPACITY = CAPACITY_DEF,
    parameter int CNT_W    = $clog2(CAPACITY + 1),
    parameter int CMP_W    = (CNT_W > POS_W) ? CNT_W : POS_W,
    parameter int IDX_W    = $clog2(CAPACITY)
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_start,
    input  wire logic [OP_W-1:0]          i_operation,
    input  wire logic signed [DATA_W-1:0] i_value,
    input  wire logic [POS_W-1:0]         i_position,
    input  wire logic signed [DATA_W-1:0] i_pass_head,
    output t_cell_cmd                     o_cmd,
    output logic [CMP_W-1:0]              o_count,
    output logic [CMP_W-1:0]              o_rank_idx,
    output logic                          o_busy,
    output logic                          o_valid,
    output logic signed [DATA_W-1:0]      o_read_value,
    output logic [STATUS_W-1:0]           o_status,
    output logic [CNT_OUT_W-1:0]          o_entry_count
);

    t_state                   r_state,       n_state;
    logic [CNT_W-1:0]         r_count,       n_count;
    logic [IDX_W-1:0]         r_scan_cnt,    n_scan_cnt;
    logic                     r_valid,       n_valid;
    logic signed [DATA_W-1:0] r_read_value,  n_read_value;
    t_status                  r_status,      n_status;
    logic [CNT_OUT_W-1:0]     r_entry_count, n_entry_count;

    logic [CMP_W-1:0] w_pos_ext;
    logic [CMP_W-1:0] w_count_ext;
    logic             w_rank_ok;
    logic             w_full;
    logic             w_accept;

    // Rank check against the current count.
    assign w_pos_ext   = CMP_W'(i_position);
    assign w_count_ext = CMP_W'(r_count);
    assign w_rank_ok   = (w_pos_ext != '0) && (w_pos_ext <= w_count_ext);
    assign w_full      = r_count == CNT_W'(CAPACITY);
    assign w_accept    = i_start && (r_state == S_IDLE);
    assign o_rank_idx  = w_pos_ext - CMP_W'(1);
    assign o_count     = w_count_ext;

    // State and control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_valid <= n_valid;
        end
    end

    // Result and scan registers.
    always_ff @(posedge i_clk) begin
        r_scan_cnt    <= n_scan_cnt;
        r_read_value  <= n_read_value;
        r_status      <= n_status;
        r_entry_count <= n_entry_count;
    end

    // Decode requests, drive the cell command and form the result beat.
    always_comb begin
        n_state       = r_state;
        n_count       = r_count;
        n_scan_cnt    = r_scan_cnt;
        n_valid       = 1'b0;
        n_read_value  = r_read_value;
        n_status      = r_status;
        n_entry_count = r_entry_count;
        o_cmd.op      = CELL_HOLD;
        o_cmd.value   = i_value;
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_valid      = 1'b1;
                    n_read_value = '0;
                    n_status     = ST_OK;
                    if (i_operation == OP_INSERT) begin
                        if (w_full) begin
                            n_status = ST_FULL;
                        end else begin
                            o_cmd.op = CELL_INSERT;
                            n_count  = r_count + CNT_W'(1);
                        end
                    end else if (i_operation == OP_GET) begin
                        if (w_rank_ok) begin
                            o_cmd.op   = CELL_LOAD;
                            n_scan_cnt = o_rank_idx[IDX_W-1:0];
                            n_state    = S_SCAN;
                            n_valid    = 1'b0;
                        end else begin
                            n_status = ST_RANGE;
                        end
                    end else if (i_operation == OP_REMOVE) begin
                        if (w_rank_ok) begin
                            o_cmd.op = CELL_REMOVE;
                            n_count  = r_count - CNT_W'(1);
                        end else begin
                            n_status = ST_RANGE;
                        end
                    end else begin
                        n_status = ST_RANGE;
                    end
                    n_entry_count = CNT_OUT_W'(n_count);
                end
            end
            S_SCAN: begin
                if (r_scan_cnt == '0) begin
                    n_valid       = 1'b1;
                    n_read_value  = i_pass_head;
                    n_status      = ST_OK;
                    n_entry_count = CNT_OUT_W'(r_count);
                    n_state       = S_IDLE;
                end else begin
                    o_cmd.op   = CELL_SHIFT;
                    n_scan_cnt = r_scan_cnt - IDX_W'(1);
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_busy        = r_state != S_IDLE;
    assign o_valid       = r_valid;
    assign o_read_value  = r_read_value;
    assign o_status      = r_status;
    assign o_entry_count = r_entry_count;

    // The count never passes the capacity.
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(CAPACITY))
        else $error("entry count above capacity");

    // An insert into a table with room adds exactly one entry.
    a_insert_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && i_operation == OP_INSERT && !w_full)
            |=> r_count == $past(r_count) + CNT_W'(1))
        else $error("insert did not grow the count");

    // A full report only comes from a full table.
    a_full_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && r_status == ST_FULL) |-> w_full)
        else $error("full status with room left");

    // No result beat while the read-out chain is still moving.
    a_scan_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN && r_scan_cnt != '0) |=> !r_valid)
        else $error("result beat during scan");

endmodule

`default_nettype wire

/* hdl/sorted_rank_table.sv */
`default_nettype none

// Sorted table of up to CAPACITY signed 32-bit values held in a row of cells.
// Request channel: start with operation, value and position is taken at a
// rising edge where start is high and busy is low. One result beat follows
// every request: o_valid is high for exactly one cycle with o_read_value,
// o_status and o_entry_count; the receiver cannot hold results off.
// For insert, remove and rejected requests the result beat appears in the
// cycle after the request and busy stays low, so a new request may be
// issued every cycle. A get copies all entries into a read-out chain and
// moves it one cell a cycle toward cell zero; the result beat follows once
// the entry at the requested position has reached cell zero. Busy stays
// high while the chain moves and drops in the cycle of the result beat,
// so the next request can be taken at the edge that takes the result.
// Insert compares the value in every cell at once and shifts the larger
// entries one cell to the right; remove shifts the tail one cell left.
// Synchronous reset empties the table (count zero) and returns the block to
// idle; stored values are not cleared and are never read before written.
module sorted_rank_table import srt_pkg::*; #(
    parameter int CAPACITY = CAPACITY_DEF
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     start,
    input  wire logic [OP_W-1:0]          i_operation,
    input  wire logic signed [DATA_W-1:0] i_value,
    input  wire logic [POS_W-1:0]         i_position,
    output logic                          busy,
    output logic                          o_valid,
    output logic signed [DATA_W-1:0]      o_read_value,
    output logic [STATUS_W-1:0]           o_status,
    output logic [CNT_OUT_W-1:0]          o_entry_count
);

    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;
    localparam int IDX_W = $clog2(CAPACITY);

    t_cell_cmd                w_cmd;
    logic [CMP_W-1:0]         w_count;
    logic [CMP_W-1:0]         w_rank_idx;
    logic                     w_gt    [CAPACITY];
    logic signed [DATA_W-1:0] w_entry [CAPACITY];
    logic signed [DATA_W-1:0] w_pass  [CAPACITY];

    // Request decode, count and result beat.
    srt_ctrl #(
        .CAPACITY (CAPACITY),
        .CNT_W    (CNT_W),
        .CMP_W    (CMP_W),
        .IDX_W    (IDX_W)
    ) u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_start       (start),
        .i_operation   (i_operation),
        .i_value       (i_value),
        .i_position    (i_position),
        .i_pass_head   (w_pass[0]),
        .o_cmd         (w_cmd),
        .o_count       (w_count),
        .o_rank_idx    (w_rank_idx),
        .o_busy        (busy),
        .o_valid       (o_valid),
        .o_read_value  (o_read_value),
        .o_status      (o_status),
        .o_entry_count (o_entry_count)
    );

    // Row of cells, cell zero holds the smallest value.
    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        logic                     w_left_gt;
        logic signed [DATA_W-1:0] w_left_entry;
        logic signed [DATA_W-1:0] w_right_entry;
        logic signed [DATA_W-1:0] w_right_pass;

        if (g == 0) begin : g_first
            assign w_left_gt    = 1'b0;
            assign w_left_entry = '0;
        end else begin : g_mid_left
            assign w_left_gt    = w_gt[g-1];
            assign w_left_entry = w_entry[g-1];
        end

        if (g == CAPACITY - 1) begin : g_last
            assign w_right_entry = w_entry[g];
            assign w_right_pass  = '0;
        end else begin : g_mid_right
            assign w_right_entry = w_entry[g+1];
            assign w_right_pass  = w_pass[g+1];
        end

        srt_cell #(
            .CMP_W (CMP_W),
            .INDEX (g)
        ) u_cell (
            .i_clk         (i_clk),
            .i_cmd         (w_cmd),
            .i_count       (w_count),
            .i_rank_idx    (w_rank_idx),
            .i_left_gt     (w_left_gt),
            .i_left_entry  (w_left_entry),
            .i_right_entry (w_right_entry),
            .i_right_pass  (w_right_pass),
            .o_gt          (w_gt[g]),
            .o_entry       (w_entry[g]),
            .o_pass        (w_pass[g])
        );
    end

endmodule

`default_nettype wire

/* bench/rank_table_checker.sv */
`timescale 1ns / 100ps

// Watches the request and result beats of the sorted rank table, keeps its own
// sorted copy of the table and compares every result beat with the oldest
// expected one.
module rank_table_checker import srt_pkg::*; #(
    parameter int CAPACITY = CAPACITY_DEF
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     start,
    input  wire logic                     busy,
    input  wire logic [OP_W-1:0]          i_operation,
    input  wire logic signed [DATA_W-1:0] i_value,
    input  wire logic [POS_W-1:0]         i_position,
    input  wire logic                     o_valid,
    input  wire logic signed [DATA_W-1:0] o_read_value,
    input  wire logic [STATUS_W-1:0]      o_status,
    input  wire logic [CNT_OUT_W-1:0]     o_entry_count,
    output int                            error_count,
    output int                            pending_count
);

    typedef struct {
        logic signed [DATA_W-1:0] read_value;
        logic [STATUS_W-1:0]      status;
        logic [CNT_OUT_W-1:0]     entry_count;
    } t_rank_result;

    // Shadow of the table contents, kept in ascending order.
    logic signed [DATA_W-1:0] shadow_entries [CAPACITY];
    int                       shadow_count;
    t_rank_result             expected_results [$];
    t_rank_result             oldest_result;
    t_rank_result             new_result;

    initial begin
        error_count   = 0;
        pending_count = 0;
        shadow_count  = 0;
    end

    // Applies one request to the shadow table and works out its result beat.
    task automatic apply_request(
        input  logic [OP_W-1:0]          op,
        input  logic signed [DATA_W-1:0] val,
        input  logic [POS_W-1:0]         rank,
        output t_rank_result             res
    );
        int slot;
        res.read_value = '0;
        res.status     = ST_OK;
        case (op)
            OP_INSERT: begin
                if (shadow_count >= CAPACITY) begin
                    res.status = ST_FULL;
                end else begin
                    // Larger entries move up one slot; equal ones stay ahead.
                    slot = shadow_count;
                    while (slot > 0 && shadow_entries[slot-1] > val) begin
                        shadow_entries[slot] = shadow_entries[slot-1];
                        slot--;
                    end
                    shadow_entries[slot] = val;
                    shadow_count++;
                end
            end
            OP_GET, OP_REMOVE: begin
                if (rank < 1 || rank > shadow_count) begin
                    res.status = ST_RANGE;
                end else if (op == OP_GET) begin
                    res.read_value = shadow_entries[rank-1];
                end else begin
                    for (slot = rank - 1; slot + 1 < shadow_count; slot++)
                        shadow_entries[slot] = shadow_entries[slot+1];
                    shadow_count--;
                end
            end
            default: begin
                res.status = ST_RANGE;
            end
        endcase
        res.entry_count = shadow_count[CNT_OUT_W-1:0];
    endtask

    task automatic note_mismatch(input string what);
        error_count++;
        if (error_count <= 10)
            $display("[%0t] mismatch: %s", $realtime, what);
    endtask

    // A result beat is checked before the request beat of the same edge is
    // predicted; the result always belongs to an earlier request.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            expected_results.delete();
            shadow_count = 0;
        end else begin
            if (o_valid) begin
                if (expected_results.size() == 0) begin
                    note_mismatch($sformatf({"result beat with none expected: ",
                                             "value %0d status %0d count %0d"},
                                            o_read_value, o_status, o_entry_count));
                end else begin
                    oldest_result = expected_results.pop_front();
                    if (o_read_value !== oldest_result.read_value
                            || o_status !== oldest_result.status
                            || o_entry_count !== oldest_result.entry_count) begin
                        note_mismatch($sformatf({"expected value %0d status %0d count %0d, ",
                                                 "got value %0d status %0d count %0d"},
                                                oldest_result.read_value, oldest_result.status,
                                                oldest_result.entry_count, o_read_value,
                                                o_status, o_entry_count));
                    end
                end
            end
            if (start && !busy) begin
                apply_request(i_operation, i_value, i_position, new_result);
                expected_results.push_back(new_result);
            end
        end
        pending_count = expected_results.size();
    end

endmodule

/* bench/tb_top.sv */
`timescale 1ns / 100ps

// Drives request beats into the sorted rank table and gives the verdict; the
// checker beside the block does all prediction and comparison.
module tb_top;
    import srt_pkg::*;

    localparam int              CAPACITY    = CAPACITY_DEF;
    localparam int              STALL_LIMIT = 2000;
    localparam logic [OP_W-1:0] OP_UNUSED   = 2'd3;

    logic                     i_clk = 1'b0;
    logic                     i_rst_n;
    logic                     start;
    logic [OP_W-1:0]          i_operation;
    logic signed [DATA_W-1:0] i_value;
    logic [POS_W-1:0]         i_position;
    logic                     busy;
    logic                     o_valid;
    logic signed [DATA_W-1:0] o_read_value;
    logic [STATUS_W-1:0]      o_status;
    logic [CNT_OUT_W-1:0]     o_entry_count;
    int                       error_count;
    int                       pending_count;

    // Entry count as the stimulus sees it, used to aim ranks at live entries.
    int                       live_count;
    int                       idle_pct;
    int                       stall_cycles;

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    sorted_rank_table #(.CAPACITY(CAPACITY)) u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .start         (start),
        .i_operation   (i_operation),
        .i_value       (i_value),
        .i_position    (i_position),
        .busy          (busy),
        .o_valid       (o_valid),
        .o_read_value  (o_read_value),
        .o_status      (o_status),
        .o_entry_count (o_entry_count)
    );

    rank_table_checker #(.CAPACITY(CAPACITY)) u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .start         (start),
        .busy          (busy),
        .i_operation   (i_operation),
        .i_value       (i_value),
        .i_position    (i_position),
        .o_valid       (o_valid),
        .o_read_value  (o_read_value),
        .o_status      (o_status),
        .o_entry_count (o_entry_count),
        .error_count   (error_count),
        .pending_count (pending_count)
    );

    // Watchdog: ends the run when no beat moves for too long.
    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_valid) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
            if (stall_cycles >= STALL_LIMIT) begin
                $display("DONE: errors detected");
                $finish;
            end
        end
    end

    // Sends one request beat, with random idle cycles ahead of it.
    task automatic send_request(
        input logic [OP_W-1:0]          op,
        input logic signed [DATA_W-1:0] val,
        input logic [POS_W-1:0]         rank
    );
        while ($urandom_range(0, 99) < idle_pct) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
        start       <= 1'b1;
        i_operation <= op;
        i_value     <= val;
        i_position  <= rank;
        @(posedge i_clk);
        while (busy)
            @(posedge i_clk);
        if (op == OP_INSERT && live_count < CAPACITY)
            live_count++;
        else if (op == OP_REMOVE && rank >= 1 && rank <= live_count)
            live_count--;
    endtask

    // Holds the sender off until every result beat has come back.
    task automatic wait_drained;
        start <= 1'b0;
        @(posedge i_clk);
        wait (pending_count == 0);
        @(posedge i_clk);
    endtask

    // Small values often enough that duplicates are common, the extremes, and otherwise any value.
    function automatic logic signed [DATA_W-1:0] pick_value;
        case ($urandom_range(0, 9))
            0:       pick_value = $urandom_range(0, 1) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
            1, 2, 3: pick_value = $signed($urandom_range(0, 15)) - 8;
            default: pick_value = $urandom();
        endcase
    endfunction

    // Mostly live ranks, sometimes zero, one past the end or anything at all.
    function automatic logic [POS_W-1:0] pick_rank;
        case ($urandom_range(0, 19))
            0:       pick_rank = '0;
            1:       pick_rank = (live_count < 127) ? POS_W'(live_count + 1) : POS_W'(127);
            2:       pick_rank = POS_W'($urandom_range(0, 127));
            default: pick_rank = (live_count > 0) ? POS_W'($urandom_range(1, live_count))
                                                  : POS_W'(0);
        endcase
    endfunction

    function automatic logic [OP_W-1:0] pick_op;
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 40)
            pick_op = OP_INSERT;
        else if (roll < 70)
            pick_op = OP_GET;
        else if (roll < 95)
            pick_op = OP_REMOVE;
        else
            pick_op = OP_UNUSED;
    endfunction

    task automatic mixed_traffic(input int beats);
        for (int n = 0; n < beats; n++)
            send_request(pick_op(), pick_value(), pick_rank());
    endtask

    initial begin
        i_rst_n     <= 1'b0;
        start       <= 1'b0;
        i_operation <= OP_INSERT;
        i_value     <= '0;
        i_position  <= '0;
        live_count   = 0;
        idle_pct     = 30;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: empty table, unknown operation, extremes, duplicates,
        // out-of-range ranks, removal at the front and in the middle.
        send_request(OP_GET, '0, 7'd1);
        send_request(OP_REMOVE, '0, 7'd0);
        send_request(OP_UNUSED, 32'sh7FFF_FFFF, 7'h7F);
        send_request(OP_INSERT, 32'sh7FFF_FFFF, 7'd0);
        send_request(OP_INSERT, 32'sh8000_0000, 7'h7F);
        send_request(OP_INSERT, 32'sd0, 7'd0);
        send_request(OP_INSERT, -32'sd1, 7'd0);
        send_request(OP_INSERT, 32'sd1, 7'd0);
        send_request(OP_INSERT, 32'sd5, 7'd0);
        send_request(OP_INSERT, 32'sd5, 7'd0);
        send_request(OP_INSERT, 32'sd5, 7'd0);
        send_request(OP_INSERT, -32'sd5, 7'd0);
        send_request(OP_GET, '0, 7'd1);
        send_request(OP_GET, '0, 7'd5);
        send_request(OP_GET, '0, 7'd10);
        send_request(OP_GET, '0, 7'd0);
        send_request(OP_GET, '0, 7'd11);
        send_request(OP_GET, '1, 7'h7F);
        send_request(OP_REMOVE, '0, 7'd10);
        send_request(OP_REMOVE, '0, 7'd1);
        send_request(OP_REMOVE, '0, 7'd4);
        send_request(OP_REMOVE, '0, 7'd8);
        send_request(OP_GET, '0, 7'd1);
        send_request(OP_GET, '0, 7'd7);
        wait_drained();

        // Random mix of all operations with idle cycles.
        mixed_traffic(200);
        wait_drained();

        // Back to back with no idling: fill the table, overflow it, read high
        // ranks of a full table.
        idle_pct = 0;
        while (live_count < CAPACITY)
            send_request(OP_INSERT, pick_value(), 7'd0);
        repeat (4) send_request(OP_INSERT, pick_value(), pick_rank());
        send_request(OP_GET, '0, POS_W'(CAPACITY));
        send_request(OP_GET, '0, POS_W'(CAPACITY + 1));
        repeat (8) send_request(OP_GET, '0, pick_rank());
        wait_drained();

        // Drain to empty with idling, then errors on the empty table and a random mix.
        idle_pct = 30;
        while (live_count > 0) begin
            if ($urandom_range(0, 3) == 0)
                send_request(OP_GET, pick_value(), pick_rank());
            send_request(OP_REMOVE, pick_value(), POS_W'($urandom_range(1, live_count)));
        end
        send_request(OP_REMOVE, '0, 7'd1);
        send_request(OP_GET, '0, 7'd1);
        mixed_traffic(60);
        wait_drained();

        repeat (80) @(posedge i_clk);
        if (error_count == 0 && pending_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
